>>> src/hash_table_linear_probe_top_assert.svh
// assertion macros for the linear-probe hash table
// no dependencies; the bodies are empty when SYNTH is defined
`ifndef HASH_TABLE_LINEAR_PROBE_TOP_ASSERT_SVH
`define HASH_TABLE_LINEAR_PROBE_TOP_ASSERT_SVH
`ifndef SYNTH
`define HTLP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HTLP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HTLP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HTLP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/hashlp_pkg.sv
// shared types and constants for the linear-probe hash table
// no dependencies
package hashlp_pkg;

    localparam int SLOTS_DEF = 256;
    localparam int CAP_W     = 9;
    localparam int COUNT_W   = 9;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    // dividend bits consumed per divider cycle
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = KEY_W / DIV_BITS;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_FIND   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [VAL_W-1:0]   found_value;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

endpackage

>>> src/hash_table_linear_probe_top.sv
// linear-probe hash table: shared divider for key mod capacity, then a probe sequencer
// depends on hashlp_pkg and hash_table_linear_probe_top_assert.svh
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------
//  request   | start / busy       | req  (req_type, key, value)
//  result    | done (1-cycle)     | rsp  (status, found_value, entry_count)
//  config    | cfg_we             | cfg_wdata (capacity_in_use)
//
// after the accepting edge a request runs through the shared 4-bit-per-cycle divider,
// then probes, S_READ per probe for an add or S_READ then S_CHECK for remove/find
// (key memory read), then the result strobe; an unknown request strobes in the next cycle
// used flags are cleared at once by rst_n, no clearing pass; key/value memories are not reset
// busy is high from accepting a known type to the result strobe; the receiver cannot stall
`include "hash_table_linear_probe_top_assert.svh"

module hash_table_linear_probe_top
    import hashlp_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             req,
    output logic             done,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    // capacity cannot exceed what the register can express
    localparam int CAP_MAX = (1 << CAP_W) - 1;
    localparam int DEPTH   = (SLOTS < CAP_MAX) ? SLOTS : CAP_MAX;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int STEP_W  = $clog2(DIV_STEPS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic               done_reg, done_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [DEPTH-1:0]   used_reg;
    logic               used_set, used_clr;

    logic [1:0]         op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [CAP_W-1:0]   ecap_reg;
    logic [KEY_W-1:0]   div_reg, div_next;
    logic [CAP_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CAP_W-1:0]   left_reg, left_next;
    rsp_t               rsp_reg, rsp_next;

    logic [KEY_W-1:0]   key_mem [DEPTH];
    logic [VAL_W-1:0]   val_mem [DEPTH];
    logic [KEY_W-1:0]   rd_key_reg;
    logic [VAL_W-1:0]   rd_val_reg;
    logic               mem_we;

    logic               accept;
    logic [CAP_W-1:0]   eff_cap;
    logic [CAP_W-1:0]   rem_step;
    logic [IDX_W-1:0]   idx_wrap;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CAP_W'(1);
        end
        else if (32'(cap_reg) > DEPTH)
        begin
            eff_cap = CAP_W'(DEPTH);
        end
        else
        begin
            eff_cap = cap_reg;
        end
    end

    // restoring remainder, DIV_BITS dividend bits per cycle
    always_comb
    begin
        logic [CAP_W:0] r;
        r = {1'b0, rem_reg};
        for (int b = 0; b < DIV_BITS; b++)
        begin
            r = {r[CAP_W-1:0], div_reg[KEY_W-1-b]};
            if (r >= {1'b0, ecap_reg})
            begin
                r = r - {1'b0, ecap_reg};
            end
        end
        rem_step = r[CAP_W-1:0];
    end

    // next probe slot with wraparound at the capacity in use
    always_comb
    begin
        logic [CAP_W:0] inc;
        inc = (CAP_W+1)'(idx_reg) + (CAP_W+1)'(1);
        if (inc >= {1'b0, ecap_reg})
        begin
            idx_wrap = '0;
        end
        else
        begin
            idx_wrap = inc[IDX_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        used_set   = 1'b0;
        used_clr   = 1'b0;
        mem_we     = 1'b0;
        div_next   = div_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        left_next  = left_reg;
        rsp_next   = rsp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == REQ_ADD || req.req_type == REQ_REMOVE ||
                        req.req_type == REQ_FIND)
                    begin
                        state_next = S_DIV;
                        div_next   = req.key;
                        rem_next   = '0;
                        step_next  = '0;
                    end
                    else
                    begin
                        done_next = 1'b1;
                        rsp_next  = '{status: ST_OK, found_value: '0, entry_count: count_reg};
                    end
                end
            end
            S_DIV:
            begin
                rem_next  = rem_step;
                div_next  = div_reg << DIV_BITS;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    idx_next   = rem_step[IDX_W-1:0];
                    left_next  = ecap_reg;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (op_reg != REQ_ADD)
                begin
                    state_next = S_CHECK;
                end
                else if (!used_reg[idx_reg])
                begin
                    mem_we     = 1'b1;
                    used_set   = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    rsp_next   = '{status: ST_OK, found_value: '0,
                                   entry_count: count_reg + COUNT_W'(1)};
                end
                else if (left_reg == CAP_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    rsp_next   = '{status: ST_NOSPACE, found_value: '0, entry_count: count_reg};
                end
                else
                begin
                    left_next = left_reg - CAP_W'(1);
                    idx_next  = idx_wrap;
                end
            end
            S_CHECK:
            begin
                if (used_reg[idx_reg] && rd_key_reg == key_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg == REQ_REMOVE)
                    begin
                        used_clr   = 1'b1;
                        count_next = count_reg - COUNT_W'(1);
                        rsp_next   = '{status: ST_OK, found_value: '0,
                                       entry_count: count_reg - COUNT_W'(1)};
                    end
                    else
                    begin
                        rsp_next = '{status: ST_OK, found_value: rd_val_reg,
                                     entry_count: count_reg};
                    end
                end
                else if (left_reg == CAP_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    rsp_next   = '{status: ST_NOTFOUND, found_value: '0, entry_count: count_reg};
                end
                else
                begin
                    left_next  = left_reg - CAP_W'(1);
                    idx_next   = idx_wrap;
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
            cap_reg   <= CAP_W'(256);
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (used_set)
            begin
                used_reg[idx_reg] <= 1'b1;
            end
            else if (used_clr)
            begin
                used_reg[idx_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.req_type;
            key_reg  <= req.key;
            val_reg  <= req.value;
            ecap_reg <= eff_cap;
        end
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        idx_reg  <= idx_next;
        left_reg <= left_next;
        rsp_reg  <= rsp_next;
    end

    // slot memories, one port each, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[idx_reg] <= key_reg;
            val_mem[idx_reg] <= val_reg;
        end
        rd_key_reg <= key_mem[idx_reg];
        rd_val_reg <= val_mem[idx_reg];
    end

    `HTLP_ASSERT_IMP(a_done_when_idle, clk, rst_n, done_reg, state_reg == S_IDLE)
    `HTLP_ASSERT_NXT(a_accept_progress, clk, rst_n, accept, busy || done_reg)
    `HTLP_ASSERT_IMP(a_count_bound, clk, rst_n, done_reg, 32'(rsp_reg.entry_count) <= DEPTH)
    `HTLP_ASSERT_IMP(a_fail_no_value, clk, rst_n, done_reg && rsp_reg.status != ST_OK, rsp_reg.found_value == '0)

endmodule
